@@ rtl/abkf_pkg.sv @@
// Shared types, command codes and fixed-point helpers for the angle/bias Kalman core.
// Used by abkf_dp, abkf_ctrl and angle_bias_kalman_fusion_core.
package abkf_pkg;

	localparam int unsigned DataWidth = 32;
	localparam int unsigned RegWidth  = 31;
	localparam int unsigned DtWidth   = 16;
	localparam int unsigned ProdWidth = 69;
	localparam int unsigned WideWidth = 70;

	localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
	localparam logic [1:0] REG_BIAS_NOISE  = 2'd1;
	localparam logic [1:0] REG_MEAS_NOISE  = 2'd2;

	localparam logic [RegWidth-1:0] ANGLE_NOISE_RST = 31'd16777;
	localparam logic [RegWidth-1:0] BIAS_NOISE_RST  = 31'd50332;
	localparam logic [RegWidth-1:0] MEAS_NOISE_RST  = 31'd503316;

	typedef enum logic [4:0] {
		ST_IDLE, ST_RATE, ST_MUL_ANG, ST_ANG, ST_DBB, ST_INNER, ST_MUL_AA, ST_AA, ST_BB,
		ST_S, ST_DIV0_GO, ST_DIV0_WAIT, ST_DIV1_GO, ST_DIV1_WAIT, ST_Y, ST_MUL_K0Y,
		ST_ANGC, ST_BIASC, ST_BAU, ST_BBU, ST_ABU, ST_AAU, ST_OUT
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_RATE, OP_MUL_ANG, OP_ANG, OP_DBB, OP_INNER, OP_MUL_AA, OP_AA, OP_BB,
		OP_S, OP_DIV0_GO, OP_K0, OP_DIV1_GO, OP_K1, OP_Y, OP_MUL_K0Y,
		OP_ANGC, OP_BIASC, OP_BAU, OP_BBU, OP_ABU, OP_AAU
	} op_t;

	typedef struct packed {
		op_t  op;
		logic capture;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} status_t;

	function automatic logic signed [WideWidth-1:0] ext32(input logic signed [31:0] v);
		return {{(WideWidth-32){v[31]}}, v};
	endfunction

	// round to nearest, halves toward +inf
	function automatic logic signed [WideWidth-1:0] rnd16(
		input logic signed [ProdWidth-1:0] x);
		logic signed [WideWidth-1:0] t;
		t = {x[ProdWidth-1], x} + 70'sd32768;
		return t >>> 16;
	endfunction

	function automatic logic signed [WideWidth-1:0] rnd30(
		input logic signed [ProdWidth-1:0] x);
		logic signed [WideWidth-1:0] t;
		t = {x[ProdWidth-1], x} + 70'sd536870912;
		return t >>> 30;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [WideWidth-1:0] v);
		logic signed [WideWidth-1:0] hi;
		logic signed [WideWidth-1:0] lo;
		hi = 70'sd2147483647;
		lo = -70'sd2147483648;
		if (v > hi) begin
			return 32'sh7FFFFFFF;
		end else if (v < lo) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

endpackage

@@ rtl/abkf_div.sv @@
// Gain divider: (num * 2^30) / den, truncated toward zero, saturated to 32 bits.
// Restoring radix-2, one quotient bit per cycle.
module abkf_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] num,
	input  logic signed [32:0] den,
	output logic               done,
	output logic signed [31:0] quot
);

	logic        busy_q;
	logic        done_q;
	logic        neg_q;
	logic [32:0] den_q;
	logic [32:0] rem_q;
	logic [30:0] low_q;
	logic [30:0] q_q;
	logic [4:0]  cnt_q;
	logic signed [31:0] res_q;

	logic [31:0] num_mag;
	logic [32:0] den_mag;
	logic [61:0] num_sh;
	logic [63:0] den_sh;
	logic [33:0] trial;
	logic        qbit;
	logic [33:0] rem_nx;
	logic [30:0] q_nx;

	always_comb begin
		num_mag = num[31] ? 32'(-num) : 32'(num);
		den_mag = den[32] ? 33'(-den) : 33'(den);
		num_sh  = {num_mag, 30'd0};
		den_sh  = {den_mag, 31'd0};
		trial   = {rem_q, low_q[30]};
		qbit    = (trial >= {1'b0, den_q});
		rem_nx  = qbit ? (trial - {1'b0, den_q}) : trial;
		q_nx    = {q_q[29:0], qbit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (den_mag == '0) begin
					done_q <= 1'b1;
				end else if ({2'b00, num_sh} >= den_sh) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd30) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[31] ^ den[32];
			den_q <= den_mag;
			rem_q <= {2'b00, num_sh[61:31]};
			low_q <= num_sh[30:0];
			q_q   <= '0;
			if (den_mag == '0) begin
				res_q <= '0;
			end else if ({2'b00, num_sh} >= den_sh) begin
				res_q <= (num[31] ^ den[32]) ? 32'sh80000000 : 32'sh7FFFFFFF;
			end
		end else if (busy_q) begin
			rem_q <= rem_nx[32:0];
			low_q <= {low_q[29:0], 1'b0};
			q_q   <= q_nx;
			if (cnt_q == 5'd30) begin
				res_q <= neg_q ? -$signed({1'b0, q_nx}) : $signed({1'b0, q_nx});
			end
		end
	end

	assign done = done_q;
	assign quot = res_q;

endmodule

@@ rtl/abkf_dp.sv @@
// Datapath: filter state, noise registers, one shared multiplier, gain divider.
// Driven by abkf_pkg::cmd_t from abkf_ctrl; uses abkf_div.
module abkf_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  abkf_pkg::cmd_t        cmd,
	output abkf_pkg::status_t     status,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [30:0]           cfg_data,
	input  logic [79:0]           in_data,
	output logic [95:0]           out_data
);

	logic signed [31:0] angle_q, bias_q, aa_q, ab_q, ba_q, bb_q;
	logic [30:0]        qa_q, qb_q, r_q;
	logic signed [31:0] z_q, gyro_q, rate_q, y_q, k0_q, k1_q;
	logic [15:0]        dt_q;
	logic signed [32:0] dbb_q;
	logic signed [34:0] inner_q;
	logic signed [32:0] s_q;
	logic signed [68:0] prod_q;
	logic [95:0]        out_q;

	logic signed [35:0] ma;
	logic signed [32:0] mb;
	logic signed [69:0] r16, r30;
	logic               div_start, div_done;
	logic signed [31:0] div_num, div_q;

	assign r16 = abkf_pkg::rnd16(prod_q);
	assign r30 = abkf_pkg::rnd30(prod_q);

	// shared multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			abkf_pkg::OP_MUL_ANG: begin
				ma = {{4{rate_q[31]}}, rate_q};
				mb = {17'd0, dt_q};
			end
			abkf_pkg::OP_ANG: begin
				ma = {{4{bb_q[31]}}, bb_q};
				mb = {17'd0, dt_q};
			end
			abkf_pkg::OP_MUL_AA: begin
				ma = {inner_q[34], inner_q};
				mb = {17'd0, dt_q};
			end
			abkf_pkg::OP_AA: begin
				ma = {5'd0, qb_q};
				mb = {17'd0, dt_q};
			end
			abkf_pkg::OP_MUL_K0Y: begin
				ma = {{4{k0_q[31]}}, k0_q};
				mb = {y_q[31], y_q};
			end
			abkf_pkg::OP_ANGC: begin
				ma = {{4{k1_q[31]}}, k1_q};
				mb = {y_q[31], y_q};
			end
			abkf_pkg::OP_BIASC: begin
				ma = {{4{k1_q[31]}}, k1_q};
				mb = {aa_q[31], aa_q};
			end
			abkf_pkg::OP_BAU: begin
				ma = {{4{k1_q[31]}}, k1_q};
				mb = {ab_q[31], ab_q};
			end
			abkf_pkg::OP_BBU: begin
				ma = {{4{k0_q[31]}}, k0_q};
				mb = {ab_q[31], ab_q};
			end
			abkf_pkg::OP_ABU: begin
				ma = {{4{k0_q[31]}}, k0_q};
				mb = {aa_q[31], aa_q};
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign div_start = (cmd.op == abkf_pkg::OP_DIV0_GO) || (cmd.op == abkf_pkg::OP_DIV1_GO);
	assign div_num   = (cmd.op == abkf_pkg::OP_DIV1_GO) ? ba_q : aa_q;

	abkf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (s_q),
		.done   (div_done),
		.quot   (div_q)
	);

	assign status.div_done = div_done;

	// noise registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qa_q <= abkf_pkg::ANGLE_NOISE_RST;
			qb_q <= abkf_pkg::BIAS_NOISE_RST;
			r_q  <= abkf_pkg::MEAS_NOISE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				abkf_pkg::REG_ANGLE_NOISE: qa_q <= cfg_data;
				abkf_pkg::REG_BIAS_NOISE:  qb_q <= cfg_data;
				abkf_pkg::REG_MEAS_NOISE:  r_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= '0;
			bias_q  <= '0;
			aa_q    <= '0;
			ab_q    <= '0;
			ba_q    <= '0;
			bb_q    <= '0;
		end else begin
			case (cmd.op)
				abkf_pkg::OP_ANG:
					angle_q <= abkf_pkg::sat32(abkf_pkg::ext32(angle_q) + r16);
				abkf_pkg::OP_INNER: begin
					ab_q <= abkf_pkg::sat32(abkf_pkg::ext32(ab_q) - {{37{dbb_q[32]}}, dbb_q});
					ba_q <= abkf_pkg::sat32(abkf_pkg::ext32(ba_q) - {{37{dbb_q[32]}}, dbb_q});
				end
				abkf_pkg::OP_AA:
					aa_q <= abkf_pkg::sat32(abkf_pkg::ext32(aa_q) + r16);
				abkf_pkg::OP_BB:
					bb_q <= abkf_pkg::sat32(abkf_pkg::ext32(bb_q) + r16);
				abkf_pkg::OP_ANGC:
					angle_q <= abkf_pkg::sat32(abkf_pkg::ext32(angle_q) + r30);
				abkf_pkg::OP_BIASC:
					bias_q <= abkf_pkg::sat32(abkf_pkg::ext32(bias_q) + r30);
				abkf_pkg::OP_BAU:
					ba_q <= abkf_pkg::sat32(abkf_pkg::ext32(ba_q) - r30);
				abkf_pkg::OP_BBU:
					bb_q <= abkf_pkg::sat32(abkf_pkg::ext32(bb_q) - r30);
				abkf_pkg::OP_ABU:
					ab_q <= abkf_pkg::sat32(abkf_pkg::ext32(ab_q) - r30);
				abkf_pkg::OP_AAU:
					aa_q <= abkf_pkg::sat32(abkf_pkg::ext32(aa_q) - r30);
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
		if (cmd.capture) begin
			z_q    <= in_data[31:0];
			gyro_q <= in_data[63:32];
			dt_q   <= in_data[79:64];
		end
		case (cmd.op)
			abkf_pkg::OP_RATE:
				rate_q <= abkf_pkg::sat32(abkf_pkg::ext32(gyro_q) - abkf_pkg::ext32(bias_q));
			abkf_pkg::OP_DBB:
				dbb_q <= r16[32:0];
			abkf_pkg::OP_INNER:
				inner_q <= {{2{dbb_q[32]}}, dbb_q} - {{3{ab_q[31]}}, ab_q}
					- {{3{ba_q[31]}}, ba_q} + {4'd0, qa_q};
			abkf_pkg::OP_S:
				s_q <= {aa_q[31], aa_q} + {2'd0, r_q};
			abkf_pkg::OP_K0:
				if (div_done) k0_q <= div_q;
			abkf_pkg::OP_K1:
				if (div_done) k1_q <= div_q;
			abkf_pkg::OP_Y:
				y_q <= abkf_pkg::sat32(abkf_pkg::ext32(z_q) - abkf_pkg::ext32(angle_q));
			default: ;
		endcase
		if (cmd.load_out) begin
			out_q <= {bias_q, rate_q, angle_q};
		end
	end

	assign out_data = out_q;

endmodule

@@ rtl/abkf_ctrl.sv @@
// Step sequencer: walks predict, gain, correct and update; owns the stream handshakes.
// Issues abkf_pkg::cmd_t to abkf_dp.
module abkf_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_tvalid,
	output logic                  in_tready,
	output logic                  out_tvalid,
	input  logic                  out_tready,
	input  abkf_pkg::status_t     status,
	output abkf_pkg::cmd_t        cmd
);

	abkf_pkg::state_t state_q, state_nx;
	logic             out_valid_q;
	logic             slot_free;

	assign slot_free = !out_valid_q || out_tready;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			abkf_pkg::ST_IDLE:      if (in_tvalid) state_nx = abkf_pkg::ST_RATE;
			abkf_pkg::ST_RATE:      state_nx = abkf_pkg::ST_MUL_ANG;
			abkf_pkg::ST_MUL_ANG:   state_nx = abkf_pkg::ST_ANG;
			abkf_pkg::ST_ANG:       state_nx = abkf_pkg::ST_DBB;
			abkf_pkg::ST_DBB:       state_nx = abkf_pkg::ST_INNER;
			abkf_pkg::ST_INNER:     state_nx = abkf_pkg::ST_MUL_AA;
			abkf_pkg::ST_MUL_AA:    state_nx = abkf_pkg::ST_AA;
			abkf_pkg::ST_AA:        state_nx = abkf_pkg::ST_BB;
			abkf_pkg::ST_BB:        state_nx = abkf_pkg::ST_S;
			abkf_pkg::ST_S:         state_nx = abkf_pkg::ST_DIV0_GO;
			abkf_pkg::ST_DIV0_GO:   state_nx = abkf_pkg::ST_DIV0_WAIT;
			abkf_pkg::ST_DIV0_WAIT: if (status.div_done) state_nx = abkf_pkg::ST_DIV1_GO;
			abkf_pkg::ST_DIV1_GO:   state_nx = abkf_pkg::ST_DIV1_WAIT;
			abkf_pkg::ST_DIV1_WAIT: if (status.div_done) state_nx = abkf_pkg::ST_Y;
			abkf_pkg::ST_Y:         state_nx = abkf_pkg::ST_MUL_K0Y;
			abkf_pkg::ST_MUL_K0Y:   state_nx = abkf_pkg::ST_ANGC;
			abkf_pkg::ST_ANGC:      state_nx = abkf_pkg::ST_BIASC;
			abkf_pkg::ST_BIASC:     state_nx = abkf_pkg::ST_BAU;
			abkf_pkg::ST_BAU:       state_nx = abkf_pkg::ST_BBU;
			abkf_pkg::ST_BBU:       state_nx = abkf_pkg::ST_ABU;
			abkf_pkg::ST_ABU:       state_nx = abkf_pkg::ST_AAU;
			abkf_pkg::ST_AAU:       state_nx = abkf_pkg::ST_OUT;
			abkf_pkg::ST_OUT:       if (slot_free) state_nx = abkf_pkg::ST_IDLE;
			default:                state_nx = abkf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.capture  = 1'b0;
		cmd.load_out = 1'b0;
		in_tready    = 1'b0;
		case (state_q)
			abkf_pkg::ST_IDLE: begin
				cmd.op      = abkf_pkg::OP_NONE;
				in_tready   = 1'b1;
				cmd.capture = in_tvalid;
			end
			abkf_pkg::ST_RATE:      cmd.op = abkf_pkg::OP_RATE;
			abkf_pkg::ST_MUL_ANG:   cmd.op = abkf_pkg::OP_MUL_ANG;
			abkf_pkg::ST_ANG:       cmd.op = abkf_pkg::OP_ANG;
			abkf_pkg::ST_DBB:       cmd.op = abkf_pkg::OP_DBB;
			abkf_pkg::ST_INNER:     cmd.op = abkf_pkg::OP_INNER;
			abkf_pkg::ST_MUL_AA:    cmd.op = abkf_pkg::OP_MUL_AA;
			abkf_pkg::ST_AA:        cmd.op = abkf_pkg::OP_AA;
			abkf_pkg::ST_BB:        cmd.op = abkf_pkg::OP_BB;
			abkf_pkg::ST_S:         cmd.op = abkf_pkg::OP_S;
			abkf_pkg::ST_DIV0_GO:   cmd.op = abkf_pkg::OP_DIV0_GO;
			abkf_pkg::ST_DIV0_WAIT: cmd.op = abkf_pkg::OP_K0;
			abkf_pkg::ST_DIV1_GO:   cmd.op = abkf_pkg::OP_DIV1_GO;
			abkf_pkg::ST_DIV1_WAIT: cmd.op = abkf_pkg::OP_K1;
			abkf_pkg::ST_Y:         cmd.op = abkf_pkg::OP_Y;
			abkf_pkg::ST_MUL_K0Y:   cmd.op = abkf_pkg::OP_MUL_K0Y;
			abkf_pkg::ST_ANGC:      cmd.op = abkf_pkg::OP_ANGC;
			abkf_pkg::ST_BIASC:     cmd.op = abkf_pkg::OP_BIASC;
			abkf_pkg::ST_BAU:       cmd.op = abkf_pkg::OP_BAU;
			abkf_pkg::ST_BBU:       cmd.op = abkf_pkg::OP_BBU;
			abkf_pkg::ST_ABU:       cmd.op = abkf_pkg::OP_ABU;
			abkf_pkg::ST_AAU:       cmd.op = abkf_pkg::OP_AAU;
			abkf_pkg::ST_OUT: begin
				cmd.op       = abkf_pkg::OP_NONE;
				cmd.load_out = slot_free;
			end
			default:                cmd.op = abkf_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= abkf_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_tvalid = out_valid_q;

endmodule

@@ rtl/angle_bias_kalman_fusion_core.sv @@
// Two-state (angle, gyro bias) Kalman filter core, Q16.16 state, Q8.24 covariance.
// Each gain division runs on the shared radix-2 divider (start, 31 quotient bits, done)
// and ends early when the divisor is zero or the gain saturates; the rest is one step
// per cycle through the single shared multiplier while the output is free. A new item
// is accepted only once the last one has been through every step; a result still
// waiting in the output register holds the step until it is taken, and then the next
// item is accepted while the new result waits there. Async active-low reset loads
// noise defaults and zeroes the state.
module angle_bias_kalman_fusion_core (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // [31:0] measured_angle, [63:32] gyro_rate, [79:64] time_step
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // [31:0] angle_estimate, [63:32] rate_estimate,
	                               // [95:64] bias_estimate
	// configuration writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,  // 0 angle noise, 1 bias noise, 2 measurement noise
	input  logic [30:0] cfg_data
);

	abkf_pkg::cmd_t    cmd;
	abkf_pkg::status_t status;

	// sequencer: walks the filter step, holds the result until taken
	abkf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_tvalid  (s_tvalid),
		.in_tready  (s_tready),
		.out_tvalid (m_tvalid),
		.out_tready (m_tready),
		.status     (status),
		.cmd        (cmd)
	);

	// arithmetic and state
	abkf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_tdata),
		.out_data  (m_tdata)
	);

endmodule

@@ test/tb.sv @@
// Testbench for angle_bias_kalman_fusion_core: random and directed angle/gyro items,
// predicted by a fixed-point Kalman model kept in the testbench. Depends on abkf_pkg.
`timescale 1ns / 100ps

module tb;

	typedef struct {
		logic signed [31:0] meas;
		logic signed [31:0] gyro;
		logic [15:0]        dt;
	} sample_t;

	typedef struct {
		logic signed [31:0] ang;
		logic signed [31:0] rate;
		logic signed [31:0] bias;
	} estimate_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;   // [31:0] measured_angle, [63:32] gyro_rate, [79:64] time_step
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;   // [31:0] angle, [63:32] rate, [95:64] bias
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [30:0] cfg_data;

	angle_bias_kalman_fusion_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// filter model state
	longint q_ang, q_bias, r_meas;
	longint x_ang, x_bias, p_aa, p_ab, p_ba, p_bb;

	sample_t   pending_samples[$];
	estimate_t expected_estimates[$];
	int        mismatch_count;
	int        cycle_count;
	bit        calm;        // stretch with no idling
	bit        feeding;

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// round to nearest, halves toward +inf; >>> on longint is a floor
	function automatic longint round_shift(longint v, int n);
		return (v + (64'sd1 << (n - 1))) >>> n;
	endfunction

	function automatic longint kalman_gain(longint num, longint den);
		if (den == 0) return 0;
		return clamp32((num * (64'sd1 << 30)) / den);
	endfunction

	// one predict/correct step; |num| <= 2^31 so num*2^30 fits 64 bits
	function automatic estimate_t filter_step(sample_t s);
		estimate_t e;
		longint z, g, dt, rate, dbb, inner, sv, k0, k1, y, p00, p01;
		z = s.meas; g = s.gyro; dt = s.dt;
		rate = clamp32(g - x_bias);
		x_ang = clamp32(x_ang + round_shift(dt * rate, 16));
		dbb = round_shift(dt * p_bb, 16);
		inner = dbb - p_ab - p_ba + q_ang;
		p_aa = clamp32(p_aa + round_shift(dt * inner, 16));
		p_ab = clamp32(p_ab - dbb);
		p_ba = clamp32(p_ba - dbb);
		p_bb = clamp32(p_bb + round_shift(dt * q_bias, 16));
		sv = p_aa + r_meas;
		k0 = kalman_gain(p_aa, sv);
		k1 = kalman_gain(p_ba, sv);
		y = clamp32(z - x_ang);
		x_ang = clamp32(x_ang + round_shift(k0 * y, 30));
		x_bias = clamp32(x_bias + round_shift(k1 * y, 30));
		p00 = p_aa; p01 = p_ab;
		p_aa = clamp32(p_aa - round_shift(k0 * p00, 30));
		p_ab = clamp32(p_ab - round_shift(k0 * p01, 30));
		p_ba = clamp32(p_ba - round_shift(k1 * p00, 30));
		p_bb = clamp32(p_bb - round_shift(k1 * p01, 30));
		e.ang = x_ang[31:0]; e.rate = rate[31:0]; e.bias = x_bias[31:0];
		return e;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		mismatch_count++;
	endtask

	task automatic add_sample(logic [31:0] m, logic [31:0] g, logic [15:0] d);
		sample_t s;
		s.meas = m; s.gyro = g; s.dt = d;
		pending_samples.push_back(s);
	endtask

	// config write at idle; model follows the same register
	task automatic write_noise(logic [1:0] idx, logic [30:0] val);
		@(posedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			abkf_pkg::REG_ANGLE_NOISE: q_ang = val;
			abkf_pkg::REG_BIAS_NOISE:  q_bias = val;
			abkf_pkg::REG_MEAS_NOISE:  r_meas = val;
			default: ;
		endcase
	endtask

	// wait until all queued items went in and all results came back
	task automatic drain();
		while (pending_samples.size() != 0 || s_tvalid || expected_estimates.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Driver: present the head of the queue; predict when it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				sample_t s;
				s = pending_samples.pop_front();
				expected_estimates.push_back(filter_step(s));
			end
			if (!s_tvalid || s_tready) begin
				if (pending_samples.size() != 0
				    && feeding && (calm || $urandom_range(99) >= 7)) begin
					sample_t n;
					n = pending_samples[0];
					s_tvalid <= 1'b1;
					s_tdata  <= {n.dt, n.gyro, n.meas};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each result with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_estimates.size() == 0) begin
					report_mismatch("unexpected item", m_tdata[31:0], '0);
				end else begin
					estimate_t e;
					e = expected_estimates.pop_front();
					if (m_tdata[31:0] !== e.ang) report_mismatch("angle", m_tdata[31:0], e.ang);
					if (m_tdata[63:32] !== e.rate) report_mismatch("rate", m_tdata[63:32], e.rate);
					if (m_tdata[95:64] !== e.bias) report_mismatch("bias", m_tdata[95:64], e.bias);
				end
			end
			m_tready <= calm || ($urandom_range(99) >= 7);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 2000000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int i, k;
		logic [30:0] noise_sets[4][3];
		mismatch_count = 0; cycle_count = 0; calm = 1'b0; feeding = 1'b0;
		cfg_we = 1'b0; cfg_index = abkf_pkg::REG_ANGLE_NOISE; cfg_data = '0;
		q_ang = abkf_pkg::ANGLE_NOISE_RST;
		q_bias = abkf_pkg::BIAS_NOISE_RST;
		r_meas = abkf_pkg::MEAS_NOISE_RST;
		x_ang = 0; x_bias = 0; p_aa = 0; p_ab = 0; p_ba = 0; p_bb = 0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero divisor first (P and R zero), extremes, saturation
		write_noise(abkf_pkg::REG_MEAS_NOISE, '0);
		write_noise(abkf_pkg::REG_ANGLE_NOISE, '0);
		add_sample(32'h0001_0000, 32'h0000_8000, 16'd0);
		add_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
		feeding = 1'b1;
		drain();
		write_noise(abkf_pkg::REG_ANGLE_NOISE, abkf_pkg::ANGLE_NOISE_RST);
		write_noise(abkf_pkg::REG_MEAS_NOISE, abkf_pkg::MEAS_NOISE_RST);
		add_sample(32'h8000_0000, 32'h8000_0000, 16'hFFFF);
		add_sample(32'h7FFF_FFFF, 32'h8000_0000, 16'h0001);
		add_sample(32'h8000_0000, 32'h7FFF_FFFF, 16'h8000);
		add_sample('0, '0, '0);
		add_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		add_sample(32'h0000_0001, 32'h0000_0001, 16'h0001);
		add_sample(32'h5555_5555, 32'hAAAA_AAAA, 16'h5555);
		add_sample(32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA);
		drain();
		// huge noise drives P toward saturation, possibly negative divisor
		write_noise(abkf_pkg::REG_ANGLE_NOISE, 31'h7FFF_FFFF);
		write_noise(abkf_pkg::REG_BIAS_NOISE, 31'h7FFF_FFFF);
		write_noise(abkf_pkg::REG_MEAS_NOISE, 31'h7FFF_FFFF);
		for (i = 0; i < 8; i++) add_sample($urandom, $urandom, 16'hFFFF);
		drain();

		// random phases under several noise settings
		noise_sets = '{'{31'd16777, 31'd50332, 31'd503316},
		               '{31'd0, 31'd0, 31'd1},
		               '{31'h7FFF_FFFF, 31'd1, 31'h7FFF_FFFF},
		               '{31'd1000, 31'h7FFF_FFFF, 31'd0}};
		for (k = 0; k < 4; k++) begin
			write_noise(abkf_pkg::REG_ANGLE_NOISE, noise_sets[k][0]);
			write_noise(abkf_pkg::REG_BIAS_NOISE, noise_sets[k][1]);
			write_noise(abkf_pkg::REG_MEAS_NOISE, noise_sets[k][2]);
			// out-of-range index must be ignored
			@(posedge clk);
			cfg_we <= 1'b1; cfg_index <= 2'd3; cfg_data <= 31'($urandom);
			@(posedge clk);
			cfg_we <= 1'b0;
			calm = (k == 1);
			for (i = 0; i < 250; i++) begin
				case ($urandom_range(3))
					0: add_sample($urandom, $urandom, 16'($urandom));
					// realistic small angles/rates and ms-scale steps
					default: add_sample($signed($urandom_range(0, 32'h00B4_0000)) - 32'sh005A_0000,
					                   $signed($urandom_range(0, 32'h0014_0000)) - 32'sh000A_0000,
					                   16'($urandom_range(0, 700)));
				endcase
			end
			drain();
		end
		calm = 1'b0;

		if (mismatch_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
